// File: rtl/cellular_automaton_cell_update_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cell update core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_CELL_UPDATE_CORE_ASSERT_SVH
`define CELLULAR_AUTOMATON_CELL_UPDATE_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define CACU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define CACU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cacu_pkg.sv
// ----------------------------------------------------------------------------
// cacu_pkg
// Types, codes and constants shared by the cell update pipeline.
// ----------------------------------------------------------------------------
package cacu_pkg;

  localparam int CELL_BITS_DEF = 8;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int NBR_COUNT     = 8;
  localparam int PAIR_COUNT    = NBR_COUNT / 2;
  localparam int CNT_W         = $clog2(NBR_COUNT + 1);

  localparam logic [CFG_W-1:0] BZ_MAX_RST  = 8'd255;
  localparam logic [CFG_W-1:0] BZ_GAIN_RST = 8'd1;

  typedef enum logic [1:0] {
    MODE_LIFE  = 2'd0,
    MODE_BRAIN = 2'd1,
    MODE_WIRE  = 2'd2,
    MODE_BZ    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE_MODE = 2'd0,
    REG_BZ_MAX    = 2'd1,
    REG_BZ_GAIN   = 2'd2
  } reg_idx_t;

  localparam int BRAIN_DEAD  = 0;
  localparam int BRAIN_ALIVE = 1;
  localparam int BRAIN_DYING = 2;
  localparam int BRAIN_BIRTH = 2;

  localparam int WIRE_EMPTY = 0;
  localparam int WIRE_HEAD  = 1;
  localparam int WIRE_TAIL  = 2;
  localparam int WIRE_COND  = 3;
  localparam int WIRE_FIRE_LO = 1;
  localparam int WIRE_FIRE_HI = 2;

  localparam int LIFE_DEAD    = 0;
  localparam int LIFE_ALIVE   = 1;
  localparam int LIFE_KEEP_LO = 2;
  localparam int LIFE_KEEP_HI = 3;
  localparam int LIFE_BIRTH   = 3;

  localparam int BZ_SUM_SHIFT = 3;

  typedef struct packed {
    logic  adv;
    mode_t mode;
  } pipe_ctrl_t;

  // fraction bits of the reciprocal; keeps the divide exact for sums of eight cells
  function automatic int recip_shift(input int cell_bits);
    return cell_bits + 6;
  endfunction

endpackage

// File: rtl/cacu_reduce.sv
// ----------------------------------------------------------------------------
// cacu_reduce
// Stages 1 and 2: neighbor flag counts, pair sums, then the neighbor sum.
// ----------------------------------------------------------------------------
module cacu_reduce #(
  parameter int CELL_BITS = cacu_pkg::CELL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cacu_pkg::pipe_ctrl_t      ctrl,
  input  logic                      in_valid,
  input  logic [CELL_BITS-1:0]      nbr [cacu_pkg::NBR_COUNT],
  input  logic [CELL_BITS-1:0]      center,
  output logic                      s2_valid,
  output logic [CELL_BITS-1:0]      s2_center,
  output logic [CELL_BITS+2:0]      s2_nsum,
  output logic [cacu_pkg::CNT_W-1:0] s2_ones,
  output logic [cacu_pkg::CNT_W-1:0] s2_nz
);

  localparam int PAIR_W = CELL_BITS + 1;
  localparam int NSUM_W = CELL_BITS + 3;

  logic                       s1_valid;
  logic [CELL_BITS-1:0]       s1_center;
  logic [PAIR_W-1:0]          s1_pair [cacu_pkg::PAIR_COUNT];
  logic [cacu_pkg::CNT_W-1:0] s1_ones;
  logic [cacu_pkg::CNT_W-1:0] s1_nz;

  logic [PAIR_W-1:0]          pair_next [cacu_pkg::PAIR_COUNT];
  logic [cacu_pkg::CNT_W-1:0] ones_next;
  logic [cacu_pkg::CNT_W-1:0] nz_next;

  always_comb begin
    ones_next = '0;
    nz_next   = '0;
    for (int k = 0; k < cacu_pkg::PAIR_COUNT; k++) begin
      pair_next[k] = PAIR_W'(nbr[2*k]) + PAIR_W'(nbr[2*k+1]);
    end
    for (int k = 0; k < cacu_pkg::NBR_COUNT; k++) begin
      if (nbr[k] == CELL_BITS'(cacu_pkg::BRAIN_ALIVE)) begin
        ones_next = ones_next + cacu_pkg::CNT_W'(1);
      end
      if (nbr[k] != '0) begin
        nz_next = nz_next + cacu_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (ctrl.adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      s1_center <= center;
      s1_pair   <= pair_next;
      s1_ones   <= ones_next;
      s1_nz     <= nz_next;
      s2_center <= s1_center;
      s2_nsum   <= (NSUM_W'(s1_pair[0]) + NSUM_W'(s1_pair[1]))
                 + (NSUM_W'(s1_pair[2]) + NSUM_W'(s1_pair[3]));
      s2_ones   <= s1_ones;
      s2_nz     <= s1_nz;
    end
  end

endmodule

// File: rtl/cacu_rule.sv
// ----------------------------------------------------------------------------
// cacu_rule
// Stage 3: rule evaluation per mode and the reciprocal multiply for the
// reaction average.
// ----------------------------------------------------------------------------
module cacu_rule #(
  parameter int CELL_BITS = cacu_pkg::CELL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cacu_pkg::pipe_ctrl_t            ctrl,
  input  logic [cacu_pkg::CFG_W-1:0]      bz_max_level,
  input  logic [cacu_pkg::CFG_W-1:0]      bz_gain,
  input  logic                            s2_valid,
  input  logic [CELL_BITS-1:0]            s2_center,
  input  logic [CELL_BITS+2:0]            s2_nsum,
  input  logic [cacu_pkg::CNT_W-1:0]      s2_ones,
  input  logic [cacu_pkg::CNT_W-1:0]      s2_nz,
  output logic                            s3_valid,
  output logic                            s3_use_div,
  output logic [CELL_BITS-1:0]            s3_res,
  output logic [CELL_BITS+3+cacu_pkg::recip_shift(CELL_BITS):0] s3_prod
);

  localparam int NSUM_W = CELL_BITS + 3;
  localparam int SUM_W  = CELL_BITS + 4;
  localparam int VAL_W  = ((CELL_BITS + 1 > cacu_pkg::CFG_W) ? CELL_BITS + 1
                                                              : cacu_pkg::CFG_W) + 1;
  localparam int K      = cacu_pkg::recip_shift(CELL_BITS);
  localparam int REC_W  = K + 1;
  localparam int PROD_W = NSUM_W + REC_W;

  // ceil(2^K / d); entry 0 gives a zero quotient when no cell is active
  localparam logic [REC_W-1:0] RECIP [cacu_pkg::NBR_COUNT+1] = '{
    REC_W'(0),
    REC_W'(2**K),
    REC_W'((2**K + 1) / 2),
    REC_W'((2**K + 2) / 3),
    REC_W'((2**K + 3) / 4),
    REC_W'((2**K + 4) / 5),
    REC_W'((2**K + 5) / 6),
    REC_W'((2**K + 6) / 7),
    REC_W'((2**K + 7) / 8)
  };

  logic [CELL_BITS-1:0] res_next;
  logic                 use_div_next;
  logic [CELL_BITS-1:0] life_res, brain_res, wire_res, bz_res;
  logic [SUM_W-1:0]     total;
  logic [VAL_W-1:0]     bz_v;
  logic [VAL_W-1:0]     max_ext;
  logic                 ones_fire;

  always_comb begin
    // life
    life_res = s2_center;
    if (s2_center != '0) begin
      if (s2_nsum < NSUM_W'(cacu_pkg::LIFE_KEEP_LO) || s2_nsum > NSUM_W'(cacu_pkg::LIFE_KEEP_HI))
      begin
        life_res = CELL_BITS'(cacu_pkg::LIFE_DEAD);
      end
    end else if (s2_nsum == NSUM_W'(cacu_pkg::LIFE_BIRTH)) begin
      life_res = CELL_BITS'(cacu_pkg::LIFE_ALIVE);
    end

    // brain
    if (s2_center == CELL_BITS'(cacu_pkg::BRAIN_ALIVE)) begin
      brain_res = CELL_BITS'(cacu_pkg::BRAIN_DYING);
    end else if (s2_center == CELL_BITS'(cacu_pkg::BRAIN_DEAD) &&
                 s2_ones == cacu_pkg::CNT_W'(cacu_pkg::BRAIN_BIRTH)) begin
      brain_res = CELL_BITS'(cacu_pkg::BRAIN_ALIVE);
    end else begin
      brain_res = CELL_BITS'(cacu_pkg::BRAIN_DEAD);
    end

    // wireworld
    ones_fire = (s2_ones == cacu_pkg::CNT_W'(cacu_pkg::WIRE_FIRE_LO)) ||
                (s2_ones == cacu_pkg::CNT_W'(cacu_pkg::WIRE_FIRE_HI));
    if (s2_center == CELL_BITS'(cacu_pkg::WIRE_HEAD)) begin
      wire_res = CELL_BITS'(cacu_pkg::WIRE_TAIL);
    end else if (s2_center == CELL_BITS'(cacu_pkg::WIRE_TAIL)) begin
      wire_res = CELL_BITS'(cacu_pkg::WIRE_COND);
    end else if (s2_center == CELL_BITS'(cacu_pkg::WIRE_COND)) begin
      wire_res = ones_fire ? CELL_BITS'(cacu_pkg::WIRE_HEAD) : CELL_BITS'(cacu_pkg::WIRE_COND);
    end else begin
      wire_res = CELL_BITS'(cacu_pkg::WIRE_EMPTY);
    end

    // reaction, active cell
    total   = SUM_W'(s2_nsum) + SUM_W'(s2_center);
    max_ext = VAL_W'(bz_max_level);
    bz_v    = VAL_W'(total >> cacu_pkg::BZ_SUM_SHIFT) + VAL_W'(bz_gain);
    bz_res  = (bz_v > max_ext) ? CELL_BITS'(bz_max_level) : CELL_BITS'(bz_v);
    if (VAL_W'(s2_center) >= max_ext) begin
      bz_res = '0;
    end

    use_div_next = 1'b0;
    unique case (ctrl.mode)
      cacu_pkg::MODE_LIFE:  res_next = life_res;
      cacu_pkg::MODE_BRAIN: res_next = brain_res;
      cacu_pkg::MODE_WIRE:  res_next = wire_res;
      cacu_pkg::MODE_BZ: begin
        res_next     = bz_res;
        use_div_next = (s2_center == '0) && (max_ext != '0);
      end
      default:              res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ctrl.adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      s3_res     <= res_next;
      s3_use_div <= use_div_next;
      s3_prod    <= PROD_W'(s2_nsum) * PROD_W'(RECIP[s2_nz]);
    end
  end

endmodule

// File: rtl/cellular_automaton_cell_update_core.sv
// ----------------------------------------------------------------------------
// cellular_automaton_cell_update_core
// Next value of the center cell of a 3x3 neighborhood under a selectable rule.
// ----------------------------------------------------------------------------
// Takes one neighborhood beat per clock and returns one next_value beat per
// input beat, in order. Four register stages: count/pair-sum, neighbor sum,
// rule evaluation with reciprocal multiply, and the output register; out_valid
// rises when the accepted beat reaches the output register.
// Sustained rate is one beat per cycle; while a result waits with out_ready
// low the whole pipe holds, and in_ready follows the output register (free or
// being taken). Write the rule registers only while the pipe is empty.
module cellular_automaton_cell_update_core #(
  parameter int CELL_BITS = cacu_pkg::CELL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cacu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cacu_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CELL_BITS-1:0]           cell_nw,
  input  logic [CELL_BITS-1:0]           cell_n,
  input  logic [CELL_BITS-1:0]           cell_ne,
  input  logic [CELL_BITS-1:0]           cell_w,
  input  logic [CELL_BITS-1:0]           cell_center,
  input  logic [CELL_BITS-1:0]           cell_e,
  input  logic [CELL_BITS-1:0]           cell_sw,
  input  logic [CELL_BITS-1:0]           cell_s,
  input  logic [CELL_BITS-1:0]           cell_se,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [CELL_BITS-1:0]           next_value
);

  localparam int K      = cacu_pkg::recip_shift(CELL_BITS);
  localparam int PROD_W = CELL_BITS + 3 + K + 1;

  cacu_pkg::mode_t             rule_mode;
  logic [cacu_pkg::CFG_W-1:0]  bz_max_level;
  logic [cacu_pkg::CFG_W-1:0]  bz_gain;

  cacu_pkg::pipe_ctrl_t        ctrl;
  logic [CELL_BITS-1:0]        nbr [cacu_pkg::NBR_COUNT];

  logic                        s2_valid;
  logic [CELL_BITS-1:0]        s2_center;
  logic [CELL_BITS+2:0]        s2_nsum;
  logic [cacu_pkg::CNT_W-1:0]  s2_ones;
  logic [cacu_pkg::CNT_W-1:0]  s2_nz;

  logic                        s3_valid;
  logic                        s3_use_div;
  logic [CELL_BITS-1:0]        s3_res;
  logic [PROD_W-1:0]           s3_prod;

  assign ctrl.adv  = !out_valid || out_ready;
  assign ctrl.mode = rule_mode;
  assign in_ready  = ctrl.adv;

  assign nbr[0] = cell_nw;
  assign nbr[1] = cell_n;
  assign nbr[2] = cell_ne;
  assign nbr[3] = cell_w;
  assign nbr[4] = cell_e;
  assign nbr[5] = cell_sw;
  assign nbr[6] = cell_s;
  assign nbr[7] = cell_se;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode    <= cacu_pkg::MODE_LIFE;
      bz_max_level <= cacu_pkg::BZ_MAX_RST;
      bz_gain      <= cacu_pkg::BZ_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cacu_pkg::reg_idx_t'(cfg_index))
        cacu_pkg::REG_RULE_MODE: rule_mode    <= cacu_pkg::mode_t'(cfg_data[1:0]);
        cacu_pkg::REG_BZ_MAX:    bz_max_level <= cfg_data;
        cacu_pkg::REG_BZ_GAIN:   bz_gain      <= cfg_data;
        default: ;
      endcase
    end
  end

  cacu_reduce #(.CELL_BITS(CELL_BITS)) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_valid  (in_valid),
    .nbr       (nbr),
    .center    (cell_center),
    .s2_valid  (s2_valid),
    .s2_center (s2_center),
    .s2_nsum   (s2_nsum),
    .s2_ones   (s2_ones),
    .s2_nz     (s2_nz)
  );

  cacu_rule #(.CELL_BITS(CELL_BITS)) u_rule (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .bz_max_level (bz_max_level),
    .bz_gain      (bz_gain),
    .s2_valid     (s2_valid),
    .s2_center    (s2_center),
    .s2_nsum      (s2_nsum),
    .s2_ones      (s2_ones),
    .s2_nz        (s2_nz),
    .s3_valid     (s3_valid),
    .s3_use_div   (s3_use_div),
    .s3_res       (s3_res),
    .s3_prod      (s3_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      next_value <= s3_use_div ? CELL_BITS'(s3_prod >> K) : s3_res;
    end
  end

endmodule

// File: rtl/cacu_checker.sv
// ----------------------------------------------------------------------------
// cacu_checker
// Port-level checks on the cell update core, bound to the top level.
// ----------------------------------------------------------------------------
`include "cellular_automaton_cell_update_core_assert.svh"

module cacu_checker #(
  parameter int CELL_BITS = cacu_pkg::CELL_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CELL_BITS-1:0] next_value
);

  // stalled result beat stays up
  `CACU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped while stalled")

  // stalled result beat keeps its value
  `CACU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(next_value), "out beat changed while stalled")

  // pipe moves exactly when the output register frees up
  `CACU_ASSERT_NOW(a_ready_link, 1'b1, in_ready == (!out_valid || out_ready), "in_ready out of step with output")

  // reset empties the pipe
  `CACU_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result beat right after reset")

endmodule

bind cellular_automaton_cell_update_core cacu_checker #(.CELL_BITS(CELL_BITS)) u_cacu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .next_value (next_value)
);
